// ----- hw/rtl/kcm_pkg.sv -----
// Shared types, constants and helpers for the key driven cursor motion block.
// Used by kcm_ctrl, kcm_datapath and the top level; depends on nothing.
package kcm_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned Buttons   = 3;
  localparam int unsigned Dirs      = 4;
  localparam int unsigned SpeedW    = 24;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned InW       = 16;
  localparam int unsigned OutW      = 40;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned DivSteps  = FracBits / 2;

  localparam logic [16:0] OneFx     = 17'(1 << FracBits);
  localparam logic [16:0] FactorMin = 17'((1 << FracBits) / 100);

  localparam logic [1:0] DirUp    = 2'd0;
  localparam logic [1:0] DirDown  = 2'd1;
  localparam logic [1:0] DirLeft  = 2'd2;
  localparam logic [1:0] DirRight = 2'd3;

  localparam logic [2:0] RegBase  = 3'd0;
  localparam logic [2:0] RegTop   = 3'd1;
  localparam logic [2:0] RegAccel = 3'd2;
  localparam logic [2:0] RegRise  = 3'd3;
  localparam logic [2:0] RegFall  = 3'd4;
  localparam logic [2:0] RegFine  = 3'd5;
  localparam logic [2:0] RegWheel = 3'd6;
  localparam logic [2:0] RegFloor = 3'd7;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_LOAD, OP_DIV, OP_SQ, OP_CUBE, OP_BASE, OP_TOP,
    OP_SUM, OP_FINE, OP_FIX, OP_STEP, OP_UPD, OP_WMUL, OP_WACC, OP_FIN
  } kcm_op_e;

  typedef struct packed {
    kcm_op_e    op;
    logic [1:0] dir;
  } kcm_cmd_t;

  typedef struct packed {
    logic enabled;
    logic held;
  } kcm_sts_t;

  function automatic logic [SpeedW-1:0] sat24(input logic [25:0] v);
    sat24 = (v > 26'hFFFFFF) ? 24'hFFFFFF : v[SpeedW-1:0];
  endfunction

endpackage

// ----- hw/rtl/key_driven_cursor_motion.sv -----
// Top level of the key driven cursor motion block.
// Depends on kcm_pkg, kcm_ctrl and kcm_datapath.
//
// One input item is one tick of key states; it yields exactly one result item
// with pixel deltas, button edge masks and a wheel step. The time an item takes
// grows with each direction key held and is shortest with motion disabled,
// set by the per-direction pass through the one shared 24x17 multiplier and
// the two-bit-per-cycle divider for the hold ratio.
// A finished result waits in the output register while the next item is taken.
module key_driven_cursor_motion import kcm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [0] motion_enabled, [1] fine_mode, [5:2] move_keys, [8:6] click_keys,
  // [9] scroll_up_key, [10] scroll_down_key, rest zero
  input  logic [InW-1:0]      s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [9:0] delta_x, [19:10] delta_y, [22:20] press_mask, [25:23] release_mask,
  // [35:26] wheel step, rest zero
  output logic [OutW-1:0]     m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  kcm_cmd_t cmd;
  kcm_sts_t sts;

  kcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kcm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again right after accept");

  a_masks_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[22:20] & m_axis_tdata[25:23]) == 3'd0))
    else $error("button both pressed and released");

  a_dx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[9:0]) <= 10'sd257 &&
                       $signed(m_axis_tdata[9:0]) >= -10'sd257))
    else $error("delta_x out of range");

  a_wheel_step_multiple: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[35:26] != 10'd0) |-> m_axis_tdata[29:26] == 4'd0 ||
     m_axis_tdata[29:26] == 4'd8)
    else $error("wheel step not a multiple of eight");
`endif

endmodule

// ----- hw/rtl/kcm_ctrl.sv -----
// Sequencer for the cursor motion block: walks the four directions and the wheel.
// Depends on kcm_pkg; drives kcm_datapath through kcm_cmd_t.
module kcm_ctrl import kcm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  kcm_sts_t sts_i,
  output kcm_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_LOAD = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_CUBE = 4'd5;
  localparam logic [3:0] S_BASE = 4'd6;
  localparam logic [3:0] S_TOP  = 4'd7;
  localparam logic [3:0] S_SUM  = 4'd8;
  localparam logic [3:0] S_FINE = 4'd9;
  localparam logic [3:0] S_FIX  = 4'd10;
  localparam logic [3:0] S_STEP = 4'd11;
  localparam logic [3:0] S_UPD  = 4'd12;
  localparam logic [3:0] S_WMUL = 4'd13;
  localparam logic [3:0] S_WACC = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  localparam int unsigned CntW = $clog2(DivSteps);

  logic [3:0]      state_q, state_d;
  logic [1:0]      dir_q, dir_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovalid_q, ovalid_d;
  logic            slot_free;

  assign slot_free   = !ovalid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d   = state_q;
    dir_d     = dir_q;
    cnt_d     = cnt_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    cmd_o.op  = OP_NONE;
    cmd_o.dir = dir_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_CHK;
        end
      end
      S_CHK: begin
        dir_d   = DirUp;
        state_d = sts_i.enabled ? S_LOAD : S_FIN;
      end
      S_LOAD: begin
        cmd_o.op = OP_LOAD;
        cnt_d    = '0;
        state_d  = sts_i.held ? S_DIV : S_STEP;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) state_d = S_SQ;
      end
      S_SQ:   begin cmd_o.op = OP_SQ;   state_d = S_CUBE; end
      S_CUBE: begin cmd_o.op = OP_CUBE; state_d = S_BASE; end
      S_BASE: begin cmd_o.op = OP_BASE; state_d = S_TOP;  end
      S_TOP:  begin cmd_o.op = OP_TOP;  state_d = S_SUM;  end
      S_SUM:  begin cmd_o.op = OP_SUM;  state_d = S_FINE; end
      S_FINE: begin cmd_o.op = OP_FINE; state_d = S_FIX;  end
      S_FIX:  begin cmd_o.op = OP_FIX;  state_d = S_STEP; end
      S_STEP: begin cmd_o.op = OP_STEP; state_d = S_UPD;  end
      S_UPD: begin
        cmd_o.op = OP_UPD;
        if (dir_q == DirRight) begin
          state_d = S_WMUL;
        end else begin
          dir_d   = dir_q + 1'b1;
          state_d = S_LOAD;
        end
      end
      S_WMUL: begin cmd_o.op = OP_WMUL; state_d = S_WACC; end
      S_WACC: begin cmd_o.op = OP_WACC; state_d = S_FIN;  end
      S_FIN: begin
        // hold the result until the output register can take it
        if (slot_free) begin
          cmd_o.op = OP_FIN;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      dir_q    <= DirUp;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      dir_q    <= dir_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// ----- hw/rtl/kcm_datapath.sv -----
// Datapath: config registers, per-direction state, shared multiplier, divider, accumulators.
// Depends on kcm_pkg; steered by kcm_ctrl through kcm_cmd_t.
module kcm_datapath import kcm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [InW-1:0]      in_data_i,
  input  kcm_cmd_t            cmd_i,
  output kcm_sts_t            sts_o,
  output logic [OutW-1:0]     out_data_o
);

  // configuration
  logic [23:0] base_q, top_q, wheel_q;
  logic [15:0] accel_q, floor_q;
  logic [16:0] rise_q, fall_q, fine_q;

  // latched item
  logic             en_q, finem_q, sup_q, sdn_q;
  logic [3:0]       keys_q;
  logic [Buttons-1:0] clk_keys_q;

  // motion state
  logic [HoldW-1:0]  hold_q  [Dirs];
  logic [SpeedW-1:0] speed_q [Dirs];
  logic signed [16:0] fx_q, fy_q;
  logic signed [25:0] wacc_q;
  logic [Buttons-1:0] btn_q;

  // working registers
  logic [15:0] rem_q, quo_q;
  logic        tsat_q, up_q;
  logic [16:0] u_q, cube_q;
  logic [40:0] acc_q, prod_q;
  logic [23:0] target_q, d_q;
  logic [OutW-1:0] out_q;

  logic [23:0] mul_a;
  logic [16:0] mul_b;
  logic [15:0] accel;
  logic [HoldW-1:0] hold_cur, hold_inc;
  logic [SpeedW-1:0] speed_cur;

  assign accel     = (accel_q == '0) ? 16'd1 : accel_q;
  assign hold_cur  = hold_q[cmd_i.dir];
  assign speed_cur = speed_q[cmd_i.dir];
  assign hold_inc  = (hold_cur == '1) ? hold_cur : hold_cur + 1'b1;

  assign sts_o.enabled = en_q;
  assign sts_o.held    = keys_q[cmd_i.dir];
  assign out_data_o    = out_q;

  // two restoring division steps per cycle
  logic [16:0] r1, r2;
  logic [15:0] r1b;
  logic        ge1, ge2;
  always_comb begin
    r1  = {rem_q, 1'b0};
    ge1 = r1 >= {1'b0, accel};
    r1b = ge1 ? 16'(r1 - {1'b0, accel}) : r1[15:0];
    r2  = {r1b, 1'b0};
    ge2 = r2 >= {1'b0, accel};
  end

  logic [16:0] t_val, u_val;
  assign t_val = tsat_q ? OneFx : {1'b0, quo_q};
  assign u_val = OneFx - t_val;

  logic [41:0] mix_sum;
  assign mix_sum = {1'b0, acc_q} + {1'b0, prod_q};

  // smoothing step
  logic        gt;
  logic [16:0] factor_raw, factor;
  logic [40:0] step_sum;
  logic [23:0] step, speed_new;
  always_comb begin
    gt         = target_q > speed_cur;
    factor_raw = gt ? rise_q : fall_q;
    if (factor_raw < FactorMin)  factor = FactorMin;
    else if (factor_raw > OneFx) factor = OneFx;
    else                         factor = factor_raw;
    step_sum  = prod_q + 41'hFFFF;
    step      = step_sum[39:16];
    speed_new = up_q ? speed_cur + step : speed_cur - step;
    if (target_q == '0 && speed_new < {8'd0, floor_q}) speed_new = '0;
  end

  logic [23:0] rate;
  assign rate = finem_q ? sat24({1'b0, prod_q[40:16]}) : wheel_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_SQ:   begin mul_a = {7'd0, u_val};          mul_b = u_val;          end
      OP_CUBE: begin mul_a = {7'd0, prod_q[32:16]};  mul_b = u_q;            end
      OP_BASE: begin mul_a = base_q;                 mul_b = prod_q[32:16];  end
      OP_TOP:  begin mul_a = top_q;                  mul_b = OneFx - cube_q; end
      OP_FINE: begin mul_a = target_q;               mul_b = fine_q;         end
      OP_STEP: begin
        mul_a = gt ? target_q - speed_cur : speed_cur - target_q;
        mul_b = factor;
      end
      OP_WMUL: begin mul_a = wheel_q;                mul_b = fine_q;         end
      default: ;
    endcase
  end

  // end of item: pixel split, wheel split, button edges
  logic signed [25:0] ax, ay;
  logic signed [9:0]  qx, qy, dqx, dqy, wdelta;
  logic signed [16:0] rx, ry, wrem_s;
  logic [24:0] wa0, wa1, wa2, wa3;
  logic [2:0]  wq;
  logic [9:0]  wmag;
  logic signed [25:0] wacc_new;
  logic [Buttons-1:0] press, rel_mask;

  function automatic logic signed [9:0] px_quot(input logic signed [25:0] a);
    logic signed [9:0] q;
    q = 10'(a >>> FracBits);
    if (a[25] && a[15:0] != '0) q = q + 10'sd1;
    px_quot = q;
  endfunction

  localparam logic [24:0] WUnit = 25'(40 << FracBits);

  always_comb begin
    ax  = $signed({2'b0, speed_q[DirRight]}) - $signed({2'b0, speed_q[DirLeft]})
          + 26'(fx_q);
    ay  = $signed({2'b0, speed_q[DirDown]}) - $signed({2'b0, speed_q[DirUp]})
          + 26'(fy_q);
    dqx = px_quot(ax);
    dqy = px_quot(ay);
    qx  = dqx;
    qy  = dqy;
    rx  = 17'(ax - (26'(qx) <<< FracBits));
    ry  = 17'(ay - (26'(qy) <<< FracBits));
    wa0 = wacc_q[25] ? 25'(-wacc_q) : wacc_q[24:0];
    wq[2] = wa0 >= (WUnit << 2);
    wa1 = wq[2] ? wa0 - (WUnit << 2) : wa0;
    wq[1] = wa1 >= (WUnit << 1);
    wa2 = wq[1] ? wa1 - (WUnit << 1) : wa1;
    wq[0] = wa2 >= WUnit;
    wa3 = wq[0] ? wa2 - WUnit : wa2;
    wrem_s   = 17'(0);
    wacc_new = wacc_q[25] ? -$signed({1'b0, wa3}) : $signed({1'b0, wa3});
    wmag   = {2'b0, wq, 5'd0} + {4'b0, wq, 3'd0};
    wdelta = wacc_q[25] ? -$signed(wmag) : $signed(wmag);
    press    = clk_keys_q & ~btn_q;
    rel_mask = btn_q & ~clk_keys_q;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {17'd0, mul_a} * {24'd0, mul_b};
    unique case (cmd_i.op)
      OP_LOAD: begin
        tsat_q   <= hold_inc >= accel;
        rem_q    <= hold_inc;
        quo_q    <= '0;
        target_q <= '0;
      end
      OP_DIV: begin
        rem_q <= ge2 ? 16'(r2 - {1'b0, accel}) : r2[15:0];
        quo_q <= {quo_q[13:0], ge1, ge2};
      end
      OP_SQ:   u_q    <= u_val;
      OP_BASE: cube_q <= prod_q[32:16];
      OP_TOP:  acc_q  <= prod_q;
      OP_SUM:  target_q <= sat24(mix_sum[41:16]);
      OP_FIX:  if (finem_q) target_q <= sat24({1'b0, prod_q[40:16]});
      // move up when the target is at or above the current speed
      OP_STEP: up_q <= (target_q >= speed_cur);
      OP_FIN: begin
        if (en_q) out_q <= {4'd0, wdelta, rel_mask, press, dqy, dqx};
        else      out_q <= {4'd0, 10'd0, btn_q, 3'd0, 10'd0, 10'd0};
      end
      default: ;
    endcase
  end

  integer i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 24'd109227;
      top_q   <= 24'd819200;
      accel_q <= 16'd60;
      rise_q  <= 17'd19661;
      fall_q  <= 17'd26214;
      fine_q  <= 17'd16384;
      wheel_q <= 24'd327680;
      floor_q <= 16'd273;
      en_q <= 1'b0; finem_q <= 1'b0; sup_q <= 1'b0; sdn_q <= 1'b0;
      keys_q <= '0; clk_keys_q <= '0;
      for (i = 0; i < Dirs; i++) begin
        hold_q[i]  <= '0;
        speed_q[i] <= '0;
      end
      fx_q <= '0; fy_q <= '0; wacc_q <= '0; btn_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          RegBase:  base_q  <= cfg_wdata_i;
          RegTop:   top_q   <= cfg_wdata_i;
          RegAccel: accel_q <= cfg_wdata_i[15:0];
          RegRise:  rise_q  <= cfg_wdata_i[16:0];
          RegFall:  fall_q  <= cfg_wdata_i[16:0];
          RegFine:  fine_q  <= cfg_wdata_i[16:0];
          RegWheel: wheel_q <= cfg_wdata_i;
          RegFloor: floor_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      unique case (cmd_i.op)
        OP_LATCH: begin
          en_q       <= in_data_i[0];
          finem_q    <= in_data_i[1];
          keys_q     <= in_data_i[5:2];
          clk_keys_q <= in_data_i[8:6];
          sup_q      <= in_data_i[9];
          sdn_q      <= in_data_i[10];
        end
        OP_LOAD: hold_q[cmd_i.dir] <= keys_q[cmd_i.dir] ? hold_inc : '0;
        OP_UPD:  speed_q[cmd_i.dir] <= speed_new;
        OP_WACC: begin
          if (sup_q && !sdn_q)      wacc_q <= wacc_q + $signed({2'b0, rate});
          else if (sdn_q && !sup_q) wacc_q <= wacc_q - $signed({2'b0, rate});
        end
        OP_FIN: begin
          if (en_q) begin
            fx_q   <= rx;
            fy_q   <= ry;
            wacc_q <= wacc_new + 26'(wrem_s);
            btn_q  <= clk_keys_q;
          end else begin
            for (i = 0; i < Dirs; i++) begin
              hold_q[i]  <= '0;
              speed_q[i] <= '0;
            end
            fx_q <= '0; fy_q <= '0; wacc_q <= '0; btn_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for key_driven_cursor_motion: stream ticks in,
// predict each motion result in SystemVerilog and compare on the output stream.
// Depends on kcm_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;
  import kcm_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned DrainWait = 100;
  localparam int unsigned PhaseItems = 225;
  localparam int unsigned RegWidth [8] = '{24, 24, 16, 17, 17, 17, 24, 16};

  typedef struct packed {
    logic       sdn;
    logic       sup;
    logic [2:0] clicks;
    logic [3:0] keys;
    logic       fine;
    logic       en;
  } tick_t;

  typedef struct packed {
    logic signed [9:0] wheel;
    logic [2:0]        rel;
    logic [2:0]        prs;
    logic signed [9:0] dy;
    logic signed [9:0] dx;
  } motion_t;

  typedef struct {
    tick_t   tick;
    bit      typed;
    motion_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  key_driven_cursor_motion u_top (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  longint unsigned cfg_regs [8];
  longint unsigned hold_ticks [4];
  longint unsigned dir_speed [4];
  longint frac_x, frac_y, wheel_acc;
  logic [2:0] btn_held;

  motion_t pending_motion [$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;
  bit holdoff_req = 1'b0;

  function automatic longint unsigned scale_fine(longint unsigned v);
    longint unsigned r;
    r = (v * cfg_regs[RegFine]) >> FracBits;
    return (r > 64'hFFFFFF) ? 64'hFFFFFF : r;
  endfunction

  function automatic motion_t advance_tick(tick_t t);
    longint unsigned one, accel, tgt, sp, fac, d, stp, tt, u, cube, curve, rate;
    longint acc, q;
    motion_t r;
    int i;
    one = 64'd1 << FracBits;
    r = '0;
    if (!t.en) begin
      for (i = 0; i < 4; i++) begin
        hold_ticks[i] = 0;
        dir_speed[i] = 0;
      end
      frac_x = 0;
      frac_y = 0;
      wheel_acc = 0;
      r.rel = btn_held;
      btn_held = '0;
      return r;
    end
    accel = (cfg_regs[RegAccel] == 0) ? 1 : cfg_regs[RegAccel];
    for (i = 0; i < 4; i++) begin
      tgt = 0;
      sp = dir_speed[i];
      if (t.keys[i]) begin
        if (hold_ticks[i] < 64'hFFFF) hold_ticks[i]++;
        tt = (hold_ticks[i] >= accel) ? one : (hold_ticks[i] << FracBits) / accel;
        u = one - tt;
        cube = (((u * u) >> FracBits) * u) >> FracBits;
        curve = one - cube;
        tgt = (cfg_regs[RegBase] * (one - curve) + cfg_regs[RegTop] * curve) >> FracBits;
        if (tgt > 64'hFFFFFF) tgt = 64'hFFFFFF;
        if (t.fine) tgt = scale_fine(tgt);
      end else begin
        hold_ticks[i] = 0;
      end
      fac = (tgt > sp) ? cfg_regs[RegRise] : cfg_regs[RegFall];
      if (fac < one / 100) fac = one / 100;
      if (fac > one) fac = one;
      // round the step up so speed lands on its target
      if (tgt >= sp) begin
        d = tgt - sp;
        stp = (d * fac + one - 1) >> FracBits;
        sp += stp;
      end else begin
        d = sp - tgt;
        stp = (d * fac + one - 1) >> FracBits;
        sp -= stp;
      end
      if (tgt == 0 && sp < cfg_regs[RegFloor]) sp = 0;
      dir_speed[i] = sp & 64'hFFFFFF;
    end
    acc = frac_x + longint'(dir_speed[DirRight]) - longint'(dir_speed[DirLeft]);
    q = acc / longint'(one);
    frac_x = acc - q * longint'(one);
    r.dx = q[9:0];
    acc = frac_y + longint'(dir_speed[DirDown]) - longint'(dir_speed[DirUp]);
    q = acc / longint'(one);
    frac_y = acc - q * longint'(one);
    r.dy = q[9:0];
    r.prs = t.clicks & ~btn_held;
    r.rel = btn_held & ~t.clicks;
    btn_held = t.clicks;
    rate = t.fine ? scale_fine(cfg_regs[RegWheel]) : cfg_regs[RegWheel];
    if (t.sup && !t.sdn) wheel_acc += longint'(rate);
    else if (t.sdn && !t.sup) wheel_acc -= longint'(rate);
    q = wheel_acc / (40 * longint'(one));
    wheel_acc -= q * 40 * longint'(one);
    q = q * 40;
    r.wheel = q[9:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: stall pattern changes every window; long hold-off on request
  initial begin
    int mode, left, hold;
    mode = 0;
    left = 0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req && hold == 0) hold = 400;
      if (hold > 0) begin
        hold--;
        if (hold == 0) holdoff_req = 1'b0;
        m_axis_tready = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(20, 150);
        end
        left--;
        case (mode)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = 1'($urandom_range(0, 1));
          default: m_axis_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    motion_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[35:0];
      results_seen++;
      if (pending_motion.size() == 0) begin
        errors++;
        $error("motion result with none expected: %h", m_axis_tdata);
      end else begin
        want = pending_motion.pop_front();
        if (got.dx !== want.dx) begin
          errors++;
          $error("delta_x expected %0d got %0d", want.dx, got.dx);
        end
        if (got.dy !== want.dy) begin
          errors++;
          $error("delta_y expected %0d got %0d", want.dy, got.dy);
        end
        if (got.prs !== want.prs) begin
          errors++;
          $error("press_mask expected %0h got %0h", want.prs, got.prs);
        end
        if (got.rel !== want.rel) begin
          errors++;
          $error("release_mask expected %0h got %0h", want.rel, got.rel);
        end
        if (got.wheel !== want.wheel) begin
          errors++;
          $error("wheel step expected %0d got %0d", want.wheel, got.wheel);
        end
      end
    end
  end

  task automatic send_tick(tick_t t, bit typed, motion_t want);
    motion_t pred;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {5'b0, t};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = advance_tick(t);
    pending_motion.push_back(typed ? want : pred);
  endtask

  task automatic idle_for(int n);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    idle_for(0);
    while (pending_motion.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = idx;
    cfg_wdata_i = val;
    cfg_regs[idx] = val & ((64'd1 << RegWidth[idx]) - 1);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    row_t rows [$];
    tick_t t;
    tick_t cur;
    int burst, p, n, i;
    logic [23:0] v;

    cfg_regs = '{109227, 819200, 60, 19661, 26214, 16384, 327680, 273};
    for (i = 0; i < 4; i++) begin
      hold_ticks[i] = 0;
      dir_speed[i] = 0;
    end
    frac_x = 0;
    frac_y = 0;
    wheel_acc = 0;
    btn_held = '0;

    // sdn, sup, clicks, keys, fine, en
    rows = '{
      '{'{1'b0, 1'b0, 3'd7, 4'h0, 1'b0, 1'b0}, 1'b1, motion_t'(0)},
      '{'{1'b0, 1'b0, 3'd7, 4'h0, 1'b0, 1'b1}, 1'b1, motion_t'({13'd0, 3'd7, 20'd0})},
      '{'{1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 1'b0}, 1'b1, motion_t'({10'd0, 3'd7, 23'd0})},
      '{'{1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 1'b1}, 1'b1, motion_t'(0)},
      '{'{1'b0, 1'b0, 3'd1, 4'h1, 1'b0, 1'b1}, 1'b0, motion_t'(0)},
      '{'{1'b0, 1'b0, 3'd2, 4'h1, 1'b0, 1'b1}, 1'b0, motion_t'(0)},
      '{'{1'b0, 1'b0, 3'd4, 4'h2, 1'b0, 1'b1}, 1'b0, motion_t'(0)},
      '{'{1'b0, 1'b0, 3'd0, 4'h4, 1'b0, 1'b1}, 1'b0, motion_t'(0)},
      '{'{1'b0, 1'b0, 3'd0, 4'h8, 1'b0, 1'b1}, 1'b0, motion_t'(0)},
      '{'{1'b0, 1'b0, 3'd0, 4'hC, 1'b0, 1'b1}, 1'b0, motion_t'(0)},
      '{'{1'b0, 1'b0, 3'd0, 4'h3, 1'b0, 1'b1}, 1'b0, motion_t'(0)},
      '{'{1'b0, 1'b0, 3'd0, 4'hF, 1'b1, 1'b1}, 1'b0, motion_t'(0)},
      '{'{1'b0, 1'b0, 3'd0, 4'hF, 1'b1, 1'b1}, 1'b0, motion_t'(0)},
      '{'{1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 1'b1}, 1'b0, motion_t'(0)},
      '{'{1'b0, 1'b1, 3'd0, 4'h0, 1'b0, 1'b1}, 1'b0, motion_t'(0)},
      '{'{1'b0, 1'b1, 3'd0, 4'h0, 1'b0, 1'b1}, 1'b0, motion_t'(0)},
      '{'{1'b1, 1'b0, 3'd0, 4'h0, 1'b0, 1'b1}, 1'b0, motion_t'(0)},
      '{'{1'b1, 1'b1, 3'd0, 4'h0, 1'b0, 1'b1}, 1'b0, motion_t'(0)},
      '{'{1'b0, 1'b1, 3'd0, 4'h0, 1'b1, 1'b1}, 1'b0, motion_t'(0)},
      '{'{1'b0, 1'b0, 3'd5, 4'h9, 1'b0, 1'b1}, 1'b0, motion_t'(0)},
      '{'{1'b1, 1'b0, 3'd5, 4'h9, 1'b0, 1'b0}, 1'b0, motion_t'(0)}
    };

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[k]) send_tick(rows[k].tick, rows[k].typed, rows[k].want);

    cur = '0;
    cur.en = 1'b1;
    burst = 0;
    for (p = 0; p < 6; p++) begin
      // reconfigure only with the block idle
      drain();
      repeat (DrainWait) @(posedge clk_i);
      for (i = 0; i < 8; i++) begin
        case (p)
          1: v = '0;
          2: v = 24'hFFFFFF;
          3: begin
            case (i)
              RegTop, RegWheel, RegFall: v = 24'hFFFFFF;
              RegAccel: v = 24'($urandom_range(0, 8));
              RegRise, RegFine: v = 24'h10000;
              default: v = 24'($urandom_range(0, 24'hFFFFFF));
            endcase
          end
          default: v = (i == RegAccel) ? 24'($urandom_range(1, 100))
                                       : 24'($urandom_range(0, 24'hFFFFFF));
        endcase
        if (p > 0) write_reg(i[2:0], v);
      end

      for (n = 0; n < PhaseItems; n++) begin
        if (p == 2 && n == 50) holdoff_req = 1'b1;
        if (p == 3 && n == 100) drain();
        if (burst == 0) begin
          burst = $urandom_range(1, 20);
          if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 30));
        end
        burst--;
        // mostly long key holds with occasional changes
        if ($urandom_range(0, 11) == 0) cur.keys = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 3) == 0) cur.clicks = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 5) == 0) {cur.sdn, cur.sup} = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 19) == 0) cur.fine = ~cur.fine;
        cur.en = ($urandom_range(0, 40) != 0);
        t = cur;
        send_tick(t, 1'b0, motion_t'(0));
      end
    end

    drain();
    repeat (DrainWait) @(posedge clk_i);
    $display("Covered %0d motion results over six register settings", results_seen);
    $display("(reset values, all-zero, all-ones, fast ramp, two random sets).");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- key_driven_cursor_motion.f -----
hw/rtl/kcm_pkg.sv
hw/rtl/kcm_ctrl.sv
hw/rtl/kcm_datapath.sv
hw/rtl/key_driven_cursor_motion.sv
tb/sv/testbench.sv
